FILE: rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants and types for the concentric shell tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DIR_FRAC   = 30;
	localparam int MAX_SHELLS = 4;
	localparam int SHELL_IW   = 2;
	localparam int RAD_W      = 31;
	localparam int EPS_W      = 16;
	localparam int ROOT_W     = 35;
	localparam int VAL_W      = 2 * ROOT_W;
	localparam int T_W        = 39;
	// eight front stages, one per root bit, two back stages
	localparam int LATENCY    = ROOT_W + 10;

	localparam logic [RAD_W-1:0] DIST_MAX   = '1;
	localparam logic [2:0]       LAYER_NONE = 3'b111;
	localparam logic [2:0]       LC_RESET   = 3'd1;
	localparam logic [EPS_W-1:0] EPS_RESET  = 16'd7;

	typedef enum logic [2:0] {
		REG_LAYER_COUNT = 3'd0,
		REG_RADIUS_0    = 3'd1,
		REG_RADIUS_1    = 3'd2,
		REG_RADIUS_2    = 3'd3,
		REG_RADIUS_3    = 3'd4,
		REG_EPSILON     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic err;
		logic outside;
		logic en_b;
	} ctl_t;

	typedef struct packed {
		logic        err;
		logic        outside;
		logic        en_b;
		logic        ok_a;
		logic        ok_b;
		logic [35:0] b;
		logic [2:0]  loc;
		logic [2:0]  nud;
		logic        near;
	} side_t;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cst_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// cst_sqrt_pipe
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_sqrt_pipe (
	input  logic                         clk,
	input  logic [cst_pkg::VAL_W-1:0]    radicand,
	output logic [cst_pkg::ROOT_W-1:0]   root
);
	import cst_pkg::*;

	// indexed by stage
	logic [VAL_W-1:0]  rem_sk [ROOT_W];
	logic [ROOT_W-1:0] res_sk [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam int BIT = ROOT_W - 1 - k;
		logic [VAL_W-1:0]  rem_in;
		logic [VAL_W-1:0]  trial;
		logic [ROOT_W-1:0] res_in;

		if (k == 0) begin : g_first
			assign rem_in = radicand;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_sk[k-1];
			assign res_in = res_sk[k-1];
		end

		// (res + 2^BIT)^2 - res^2 = res * 2^(BIT+1) + 2^(2*BIT)
		assign trial = ({{(VAL_W-ROOT_W){1'b0}}, res_in} << (BIT + 1))
			| (VAL_W'(1) << (2 * BIT));

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_sk[k] <= rem_in - trial;
				res_sk[k] <= res_in | (ROOT_W'(1) << BIT);
			end else begin
				rem_sk[k] <= rem_in;
				res_sk[k] <= res_in;
			end
		end
	end

	assign root = res_sk[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/concentric_shell_tracker_top.sv
// ----------------------------------------------------------------------------
// concentric_shell_tracker_top
// Ray versus concentric sphere shells: boundary distance and shell lookup.
// ----------------------------------------------------------------------------
// Usage:
//  A query is a transaction taken at a clock edge with start high and busy
//  low. busy is always low: one query can enter every cycle.
//  Each query yields one result, shown for one cycle with done high.
//  The result sink cannot stall; results must be taken when done is high.
//  Latency is set by the floor square root: one root bit per stage, 35
//  stages, two roots in parallel (inner and outer sphere), between an
//  eight-stage multiply/sum front end and a two-stage select back end.
//  Registers are written through wr_en/wr_index/wr_data; the user must
//  write them only while no query is in flight, which the block does not
//  enforce. Reset clears the pipeline valid bits and loads the register
//  defaults (one shell, radii 1..4, epsilon 7 LSB).
// ----------------------------------------------------------------------------
`default_nettype none

module concentric_shell_tracker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic signed [31:0]          pos_z,
	input  logic signed [31:0]          dir_x,
	input  logic signed [31:0]          dir_y,
	input  logic signed [31:0]          dir_z,
	input  logic signed [2:0]           cur_layer,
	input  logic                        wr_en,
	input  cst_pkg::reg_idx_t           wr_index,
	input  logic [cst_pkg::RAD_W-1:0]   wr_data,
	output logic                        done,
	output logic [cst_pkg::RAD_W-1:0]   distance,
	output logic                        hit,
	output logic                        index_error,
	output logic signed [2:0]           located_layer,
	output logic signed [2:0]           nudged_layer,
	output logic                        near_surface
);
	import cst_pkg::*;

	// ---------------- registers ----------------
	logic [2:0]       layer_count_q;
	logic [RAD_W-1:0] radius_q [MAX_SHELLS];
	logic [EPS_W-1:0] epsilon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= LC_RESET;
			for (int i = 0; i < MAX_SHELLS; i++) begin
				radius_q[i] <= RAD_W'((i + 1) << FRAC_BITS);
			end
			epsilon_q <= EPS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_LAYER_COUNT: layer_count_q <= wr_data[2:0];
				REG_RADIUS_0:    radius_q[0] <= wr_data;
				REG_RADIUS_1:    radius_q[1] <= wr_data;
				REG_RADIUS_2:    radius_q[2] <= wr_data;
				REG_RADIUS_3:    radius_q[3] <= wr_data;
				REG_EPSILON:     epsilon_q <= wr_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- valid chain ----------------
	logic vld_q [LATENCY];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LATENCY; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < LATENCY; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign done = vld_q[LATENCY-1];

	// ---------------- stage 1: magnitudes, radius select ----------------
	logic [31:0]           p_in [3];
	logic [31:0]           d_in [3];
	logic [2:0]            n_used;
	logic [MAX_SHELLS-1:0] use_c;
	logic [SHELL_IW-1:0]   cur_idx;
	logic [RAD_W-1:0]      rb_c;
	ctl_t                  ctl_c;

	assign p_in[0] = pos_x;
	assign p_in[1] = pos_y;
	assign p_in[2] = pos_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	always_comb begin
		if (layer_count_q == 3'd0) begin
			n_used = 3'd1;
		end else if (layer_count_q > 3'(MAX_SHELLS)) begin
			n_used = 3'(MAX_SHELLS);
		end else begin
			n_used = layer_count_q;
		end
		for (int j = 0; j < MAX_SHELLS; j++) begin
			use_c[j] = 3'(j) < n_used;
		end
		cur_idx       = cur_layer[SHELL_IW-1:0];
		rb_c          = radius_q[cur_idx - SHELL_IW'(1)];
		ctl_c.outside = cur_layer == LAYER_NONE;
		ctl_c.err     = !ctl_c.outside
			&& (cur_layer[2] || ($unsigned(cur_layer) >= n_used));
		ctl_c.en_b    = !ctl_c.outside && !ctl_c.err && (cur_idx != '0)
			&& (rb_c != '0);
	end

	logic [31:0]           mp_s1 [3];
	logic [31:0]           md_s1 [3];
	logic                  pneg_s1 [3];
	logic                  dneg_s1 [3];
	logic [31:0]           p_s1 [3];
	logic [RAD_W-1:0]      lo_s1 [MAX_SHELLS];
	logic [31:0]           hi_s1 [MAX_SHELLS];
	logic [RAD_W-1:0]      ra_s1;
	logic [RAD_W-1:0]      rb_s1;
	logic [MAX_SHELLS-1:0] use_s1;
	ctl_t                  ctl_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mp_s1[i]   <= mag32(p_in[i]);
			md_s1[i]   <= mag32(d_in[i]);
			pneg_s1[i] <= p_in[i][31];
			dneg_s1[i] <= d_in[i][31];
			p_s1[i]    <= p_in[i];
		end
		for (int j = 0; j < MAX_SHELLS; j++) begin
			lo_s1[j] <= (radius_q[j] > RAD_W'(epsilon_q))
				? radius_q[j] - RAD_W'(epsilon_q) : '0;
			hi_s1[j] <= 32'(radius_q[j]) + 32'(epsilon_q);
		end
		ra_s1  <= ctl_c.outside ? radius_q[SHELL_IW'(n_used - 3'd1)] : radius_q[cur_idx];
		rb_s1  <= rb_c;
		use_s1 <= use_c;
		ctl_s1 <= ctl_c;
	end

	// ---------------- stage 2: products ----------------
	logic [63:0]           pr_s2 [3];
	logic                  ng_s2 [3];
	logic [63:0]           sq_s2 [3];
	logic [47:0]           nm_s2 [3];
	logic                  dneg_s2 [3];
	logic [31:0]           p_s2 [3];
	logic [61:0]           r2_s2 [MAX_SHELLS];
	logic [61:0]           lo2_s2 [MAX_SHELLS];
	logic [63:0]           hi2_s2 [MAX_SHELLS];
	logic [61:0]           ra2_s2;
	logic [61:0]           rb2_s2;
	logic [MAX_SHELLS-1:0] use_s2;
	ctl_t                  ctl_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pr_s2[i]   <= 64'(mp_s1[i]) * 64'(md_s1[i]);
			ng_s2[i]   <= pneg_s1[i] ^ dneg_s1[i];
			sq_s2[i]   <= 64'(mp_s1[i]) * 64'(mp_s1[i]);
			nm_s2[i]   <= 48'(md_s1[i]) * 48'(epsilon_q);
			dneg_s2[i] <= dneg_s1[i];
			p_s2[i]    <= p_s1[i];
		end
		for (int j = 0; j < MAX_SHELLS; j++) begin
			r2_s2[j]  <= 62'(radius_q[j]) * 62'(radius_q[j]);
			lo2_s2[j] <= 62'(lo_s1[j]) * 62'(lo_s1[j]);
			hi2_s2[j] <= 64'(hi_s1[j]) * 64'(hi_s1[j]);
		end
		ra2_s2 <= 62'(ra_s1) * 62'(ra_s1);
		rb2_s2 <= 62'(rb_s1) * 62'(rb_s1);
		use_s2 <= use_s1;
		ctl_s2 <= ctl_s1;
	end

	// ---------------- stage 3: sums, nudged position ----------------
	logic [63:0] pos_sum_c;
	logic [63:0] neg_sum_c;
	logic [33:0] q_c [3];

	always_comb begin
		logic [18:0] off;
		logic [33:0] px;
		pos_sum_c = '0;
		neg_sum_c = '0;
		for (int i = 0; i < 3; i++) begin
			if (ng_s2[i]) begin
				neg_sum_c = neg_sum_c + pr_s2[i];
			end else begin
				pos_sum_c = pos_sum_c + pr_s2[i];
			end
			// round half away from zero to Q16.16
			off    = 19'((49'(nm_s2[i]) + (49'(1) << (DIR_FRAC - 1))) >> DIR_FRAC);
			px     = {{2{p_s2[i][31]}}, p_s2[i]};
			q_c[i] = dneg_s2[i] ? px - 34'(off) : px + 34'(off);
		end
	end

	logic [63:0]           pos_s3;
	logic [63:0]           neg_s3;
	logic [63:0]           p2_s3;
	logic [33:0]           q_s3 [3];
	logic [61:0]           r2_s3 [MAX_SHELLS];
	logic [61:0]           lo2_s3 [MAX_SHELLS];
	logic [63:0]           hi2_s3 [MAX_SHELLS];
	logic [61:0]           ra2_s3;
	logic [61:0]           rb2_s3;
	logic [MAX_SHELLS-1:0] use_s3;
	ctl_t                  ctl_s3;

	always_ff @(posedge clk) begin
		pos_s3 <= pos_sum_c;
		neg_s3 <= neg_sum_c;
		p2_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		q_s3   <= q_c;
		r2_s3  <= r2_s2;
		lo2_s3 <= lo2_s2;
		hi2_s3 <= hi2_s2;
		ra2_s3 <= ra2_s2;
		rb2_s3 <= rb2_s2;
		use_s3 <= use_s2;
		ctl_s3 <= ctl_s2;
	end

	// ---------------- stage 4: b magnitude, shell lookup ----------------
	logic [2:0] loc_c;
	logic       near_c;

	always_comb begin
		loc_c  = LAYER_NONE;
		near_c = 1'b0;
		for (int j = MAX_SHELLS - 1; j >= 0; j--) begin
			if (use_s3[j] && (p2_s3 <= 64'(r2_s3[j]))) begin
				loc_c = 3'(j);
			end
			if (use_s3[j] && (64'(lo2_s3[j]) <= p2_s3) && (p2_s3 <= hi2_s3[j])) begin
				near_c = 1'b1;
			end
		end
	end

	logic [63:0]           bm_s4;
	logic                  bneg_s4;
	logic [32:0]           mq_s4 [3];
	logic [63:0]           p2_s4;
	logic [61:0]           r2_s4 [MAX_SHELLS];
	logic [61:0]           ra2_s4;
	logic [61:0]           rb2_s4;
	logic [2:0]            loc_s4;
	logic                  near_s4;
	logic [MAX_SHELLS-1:0] use_s4;
	ctl_t                  ctl_s4;

	always_ff @(posedge clk) begin
		if (pos_s3 >= neg_s3) begin
			bm_s4   <= pos_s3 - neg_s3;
			bneg_s4 <= 1'b0;
		end else begin
			bm_s4   <= neg_s3 - pos_s3;
			bneg_s4 <= 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			mq_s4[i] <= 33'(q_s3[i][33] ? (~q_s3[i] + 34'd1) : q_s3[i]);
		end
		p2_s4   <= p2_s3;
		r2_s4   <= r2_s3;
		ra2_s4  <= ra2_s3;
		rb2_s4  <= rb2_s3;
		loc_s4  <= loc_c;
		near_s4 <= near_c;
		use_s4  <= use_s3;
		ctl_s4  <= ctl_s3;
	end

	// ---------------- stage 5: round b, square nudged coords ----------------
	logic [ROOT_W-1:0]     bmr_s5;
	logic                  bneg_s5;
	logic [63:0]           qq_s5 [3];
	logic [63:0]           p2_s5;
	logic [61:0]           r2_s5 [MAX_SHELLS];
	logic [61:0]           ra2_s5;
	logic [61:0]           rb2_s5;
	logic [2:0]            loc_s5;
	logic                  near_s5;
	logic [MAX_SHELLS-1:0] use_s5;
	ctl_t                  ctl_s5;

	always_ff @(posedge clk) begin
		bmr_s5  <= ROOT_W'((65'(bm_s4) + (65'(1) << (DIR_FRAC - 1))) >> DIR_FRAC);
		bneg_s5 <= bneg_s4;
		for (int i = 0; i < 3; i++) begin
			qq_s5[i] <= 64'(mq_s4[i]) * 64'(mq_s4[i]);
		end
		p2_s5   <= p2_s4;
		r2_s5   <= r2_s4;
		ra2_s5  <= ra2_s4;
		rb2_s5  <= rb2_s4;
		loc_s5  <= loc_s4;
		near_s5 <= near_s4;
		use_s5  <= use_s4;
		ctl_s5  <= ctl_s4;
	end

	// ---------------- stage 6: b squared, nudged radius ----------------
	logic [VAL_W-1:0]      bm2_s6;
	logic [35:0]           b_s6;
	logic [63:0]           q2_s6;
	logic [63:0]           p2_s6;
	logic [61:0]           r2_s6 [MAX_SHELLS];
	logic [61:0]           ra2_s6;
	logic [61:0]           rb2_s6;
	logic [2:0]            loc_s6;
	logic                  near_s6;
	logic [MAX_SHELLS-1:0] use_s6;
	ctl_t                  ctl_s6;

	always_ff @(posedge clk) begin
		bm2_s6  <= VAL_W'(bmr_s5) * VAL_W'(bmr_s5);
		b_s6    <= bneg_s5 ? (36'd0 - 36'(bmr_s5)) : 36'(bmr_s5);
		q2_s6   <= qq_s5[0] + qq_s5[1] + qq_s5[2];
		p2_s6   <= p2_s5;
		r2_s6   <= r2_s5;
		ra2_s6  <= ra2_s5;
		rb2_s6  <= rb2_s5;
		loc_s6  <= loc_s5;
		near_s6 <= near_s5;
		use_s6  <= use_s5;
		ctl_s6  <= ctl_s5;
	end

	// ---------------- stage 7: discriminant sums, nudged lookup ----------------
	logic [2:0] nud_c;

	always_comb begin
		nud_c = LAYER_NONE;
		for (int j = MAX_SHELLS - 1; j >= 0; j--) begin
			if (use_s6[j] && (q2_s6 <= 64'(r2_s6[j]))) begin
				nud_c = 3'(j);
			end
		end
	end

	logic [VAL_W-1:0] a_a_s7;
	logic [VAL_W-1:0] a_b_s7;
	logic [35:0]      b_s7;
	logic [63:0]      p2_s7;
	logic [2:0]       loc_s7;
	logic [2:0]       nud_s7;
	logic             near_s7;
	ctl_t             ctl_s7;

	always_ff @(posedge clk) begin
		a_a_s7  <= bm2_s6 + VAL_W'(ra2_s6);
		a_b_s7  <= bm2_s6 + VAL_W'(rb2_s6);
		b_s7    <= b_s6;
		p2_s7   <= p2_s6;
		loc_s7  <= loc_s6;
		nud_s7  <= nud_c;
		near_s7 <= near_s6;
		ctl_s7  <= ctl_s6;
	end

	// ---------------- stage 8: discriminant ----------------
	logic [VAL_W-1:0] rem_a_s8;
	logic [VAL_W-1:0] rem_b_s8;
	side_t            side_s8;

	always_ff @(posedge clk) begin
		rem_a_s8        <= a_a_s7 - VAL_W'(p2_s7);
		rem_b_s8        <= a_b_s7 - VAL_W'(p2_s7);
		side_s8.err     <= ctl_s7.err;
		side_s8.outside <= ctl_s7.outside;
		side_s8.en_b    <= ctl_s7.en_b;
		side_s8.ok_a    <= VAL_W'(p2_s7) <= a_a_s7;
		side_s8.ok_b    <= VAL_W'(p2_s7) <= a_b_s7;
		side_s8.b       <= b_s7;
		side_s8.loc     <= loc_s7;
		side_s8.nud     <= nud_s7;
		side_s8.near    <= near_s7;
	end

	// ---------------- root stages ----------------
	logic [ROOT_W-1:0] root_a;
	logic [ROOT_W-1:0] root_b;
	side_t             side_sk [ROOT_W];

	cst_sqrt_pipe u_sqrt_a (
		.clk      (clk),
		.radicand (rem_a_s8),
		.root     (root_a)
	);

	cst_sqrt_pipe u_sqrt_b (
		.clk      (clk),
		.radicand (rem_b_s8),
		.root     (root_b)
	);

	always_ff @(posedge clk) begin
		side_sk[0] <= side_s8;
		for (int k = 1; k < ROOT_W; k++) begin
			side_sk[k] <= side_sk[k-1];
		end
	end

	// ---------------- stage 9: crossing candidates ----------------
	side_t                   side_r;
	logic signed [T_W-1:0]   nb_c;
	logic signed [T_W-1:0]   eps_c;
	logic signed [T_W-1:0]   tn_a_c, tf_a_c, tn_b_c, tf_b_c;

	assign side_r = side_sk[ROOT_W-1];

	always_comb begin
		nb_c   = -$signed({{(T_W-36){side_r.b[35]}}, side_r.b});
		eps_c  = $signed({{(T_W-EPS_W){1'b0}}, epsilon_q});
		tn_a_c = nb_c - $signed({{(T_W-ROOT_W){1'b0}}, root_a});
		tf_a_c = nb_c + $signed({{(T_W-ROOT_W){1'b0}}, root_a});
		tn_b_c = nb_c - $signed({{(T_W-ROOT_W){1'b0}}, root_b});
		tf_b_c = nb_c + $signed({{(T_W-ROOT_W){1'b0}}, root_b});
	end

	logic             hit_a_s9;
	logic             hit_b_s9;
	logic [T_W-2:0]   t_a_s9;
	logic [T_W-2:0]   t_b_s9;
	side_t            side_s9;

	always_ff @(posedge clk) begin
		hit_a_s9 <= !side_r.err && side_r.ok_a && ((tn_a_c > eps_c) || (tf_a_c > eps_c));
		hit_b_s9 <= side_r.en_b && side_r.ok_b && ((tn_b_c > eps_c) || (tf_b_c > eps_c));
		t_a_s9   <= (tn_a_c > eps_c) ? tn_a_c[T_W-2:0] : tf_a_c[T_W-2:0];
		t_b_s9   <= (tn_b_c > eps_c) ? tn_b_c[T_W-2:0] : tf_b_c[T_W-2:0];
		side_s9  <= side_r;
	end

	// ---------------- stage 10: nearest crossing, result register ----------------
	logic           hit_c;
	logic [T_W-2:0] t_c;

	always_comb begin
		hit_c = hit_a_s9 || hit_b_s9;
		t_c   = (hit_b_s9 && (!hit_a_s9 || (t_b_s9 < t_a_s9))) ? t_b_s9 : t_a_s9;
	end

	always_ff @(posedge clk) begin
		if (!hit_c) begin
			distance <= '0;
		end else if (t_c > (T_W-1)'(DIST_MAX)) begin
			distance <= DIST_MAX;
		end else begin
			distance <= t_c[RAD_W-1:0];
		end
		hit           <= hit_c;
		index_error   <= side_s9.err;
		located_layer <= side_s9.loc;
		nudged_layer  <= side_s9.nud;
		near_surface  <= side_s9.near;
	end

endmodule

`default_nettype wire

FILE: rtl/cst_check.sv
// ----------------------------------------------------------------------------
// cst_check
// Port-level checks on the concentric shell tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        done,
	input  logic                        hit,
	input  logic                        index_error,
	input  logic [cst_pkg::RAD_W-1:0]   distance
);
	import cst_pkg::*;

	// every accepted query comes back as a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("query result missing at fixed latency");

	// no result without a query
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching query");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (distance == '0))
		else $error("miss with nonzero distance");

	a_err_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> !hit)
		else $error("hit reported on bad layer index");

	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (distance != '0))
		else $error("hit with zero distance");

endmodule

bind concentric_shell_tracker_top cst_check u_cst_check (.*);

`default_nettype wire

FILE: test/shell_query_checker.sv
// ----------------------------------------------------------------------------
// shell_query_checker
// Watches accepted shell queries, computes the expected geometry result
// (boundary distance, hit, index error, located and nudged shell, near
// surface) and compares each done strobe against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shell_query_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [2:0]  cur_layer,
	input  logic               wr_en,
	input  cst_pkg::reg_idx_t  wr_index,
	input  logic [30:0]        wr_data,
	input  logic               done,
	input  logic [30:0]        distance,
	input  logic               hit,
	input  logic               index_error,
	input  logic signed [2:0]  located_layer,
	input  logic signed [2:0]  nudged_layer,
	input  logic               near_surface,
	output int                 fail_count,
	output int                 pending
);
	import cst_pkg::*;

	typedef struct packed {
		logic [30:0] dst;
		logic        hit;
		logic        err;
		logic [2:0]  loc;
		logic [2:0]  nud;
		logic        near;
	} shell_result_t;

	shell_result_t expected_q[$];
	logic [2:0]  shell_cnt;
	logic [30:0] radii[4];
	logic [15:0] eps;

	assign pending = expected_q.size();

	// round a Q.46 (or dir*eps Q.46) magnitude to Q16.16, half away from zero
	function automatic longint round_q30(input logic [127:0] m, input bit neg);
		longint q;
		q = longint'((m + (128'd1 << 29)) >> 30);
		return neg ? -q : q;
	endfunction

	function automatic logic [127:0] isqrt(input logic [127:0] v);
		logic [127:0] r;
		logic [127:0] c;
		r = 0;
		for (int k = 63; k >= 0; k--) begin
			c = r | (128'd1 << k);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	// nearest crossing beyond epsilon of sphere radius r
	function automatic bit sphere_cross(input longint b, input logic [127:0] p2,
			input logic [30:0] r, output longint t);
		logic [127:0] a;
		longint bm, root, tn, tf;
		bm = b < 0 ? -b : b;
		a = 128'(bm) * 128'(bm) + 128'(r) * 128'(r);
		t = 0;
		if (p2 > a)
			return 0;
		root = longint'(isqrt(a - p2));
		tn = -b - root;
		tf = -b + root;
		if (tn > longint'(eps)) begin
			t = tn;
			return 1;
		end
		if (tf > longint'(eps)) begin
			t = tf;
			return 1;
		end
		return 0;
	endfunction

	function automatic logic [2:0] find_shell(input logic [127:0] m2, input int n);
		for (int i = 0; i < n; i++)
			if (m2 <= 128'(radii[i]) * 128'(radii[i]))
				return 3'(i);
		return LAYER_NONE;
	endfunction

	function automatic shell_result_t predict_shell_query(input longint p[3],
			input longint d[3], input int cur);
		shell_result_t r;
		logic [127:0] pos_sum, neg_sum, p2, q2, pr, lo, hi;
		longint q[3], b, t, t2, pm, dm;
		int n;
		bit h, h2;
		n = shell_cnt == 0 ? 1 : (shell_cnt > 4 ? 4 : int'(shell_cnt));
		pos_sum = 0;
		neg_sum = 0;
		p2 = 0;
		q2 = 0;
		for (int i = 0; i < 3; i++) begin
			pm = p[i] < 0 ? -p[i] : p[i];
			dm = d[i] < 0 ? -d[i] : d[i];
			pr = 128'(pm) * 128'(dm);
			if ((p[i] < 0) != (d[i] < 0))
				neg_sum += pr;
			else
				pos_sum += pr;
			p2 += 128'(pm) * 128'(pm);
			q[i] = p[i] + round_q30(128'(dm) * 128'(eps), d[i] < 0);
			pm = q[i] < 0 ? -q[i] : q[i];
			q2 += 128'(pm) * 128'(pm);
		end
		b = pos_sum >= neg_sum ? round_q30(pos_sum - neg_sum, 0)
			: round_q30(neg_sum - pos_sum, 1);
		r = '0;
		t = 0;
		h = 0;
		if (cur == -1)
			h = sphere_cross(b, p2, radii[n-1], t);
		else if (cur < 0 || cur >= n)
			r.err = 1;
		else begin
			h = sphere_cross(b, p2, radii[cur], t);
			if (cur > 0 && radii[cur-1] > 0) begin
				h2 = sphere_cross(b, p2, radii[cur-1], t2);
				if (h2) begin
					if (!h || t2 < t)
						t = t2;
					h = 1;
				end
			end
		end
		if (!h)
			t = 0;
		if (t > longint'(DIST_MAX))
			t = longint'(DIST_MAX);
		r.dst = 31'(t);
		r.hit = h;
		r.loc = find_shell(p2, n);
		r.nud = find_shell(q2, n);
		for (int i = 0; i < n; i++) begin
			lo = radii[i] > eps ? 128'(radii[i] - eps) : 0;
			hi = 128'(radii[i]) + 128'(eps);
			if (lo * lo <= p2 && p2 <= hi * hi)
				r.near = 1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shell_result_t got, want;
		longint p[3], d[3];
		if (!arst_n) begin
			shell_cnt <= LC_RESET;
			for (int i = 0; i < 4; i++)
				radii[i] <= 31'((i + 1) << FRAC_BITS);
			eps <= EPS_RESET;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (start && !busy) begin
				p = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
				d = '{longint'(dir_x), longint'(dir_y), longint'(dir_z)};
				expected_q.push_back(predict_shell_query(p, d, int'(cur_layer)));
			end
			if (done) begin
				got = '{distance, hit, index_error, located_layer, nudged_layer,
					near_surface};
				if (expected_q.size() == 0) begin
					$error("unexpected result transaction");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.dst != want.dst)
							$error("distance exp %0d got %0d", want.dst, got.dst);
						if (got.hit != want.hit)
							$error("hit exp %0d got %0d", want.hit, got.hit);
						if (got.err != want.err)
							$error("index_error exp %0d got %0d", want.err, got.err);
						if (got.loc != want.loc)
							$error("located_layer exp %0d got %0d", want.loc, got.loc);
						if (got.nud != want.nud)
							$error("nudged_layer exp %0d got %0d", want.nud, got.nud);
						if (got.near != want.near)
							$error("near_surface exp %0d got %0d", want.near, got.near);
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_LAYER_COUNT: shell_cnt <= wr_data[2:0];
					REG_RADIUS_0:    radii[0] <= wr_data;
					REG_RADIUS_1:    radii[1] <= wr_data;
					REG_RADIUS_2:    radii[2] <= wr_data;
					REG_RADIUS_3:    radii[3] <= wr_data;
					REG_EPSILON:     eps <= wr_data[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives shell queries and register settings into the shell tracker under
// idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import cst_pkg::*;

	localparam int ONE = 1 << FRAC_BITS;
	localparam int UNIT = 1 << DIR_FRAC;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic signed [2:0] cur_layer = 0;
	logic wr_en = 0;
	reg_idx_t wr_index = REG_LAYER_COUNT;
	logic [30:0] wr_data = 0;
	logic done, hit, index_error, near_surface;
	logic [30:0] distance;
	logic signed [2:0] located_layer, nudged_layer;
	int fail_count, pending;
	longint cycles = 0;
	int idle_pct = 0;
	logic [30:0] rad[4] = '{31'(ONE), 31'(2 * ONE), 31'(3 * ONE), 31'(4 * ONE)};

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	concentric_shell_tracker_top dut (.*);

	shell_query_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
	endtask

	// wait for the pipeline to empty before touching registers
	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic send_query(input logic [31:0] px, py, pz, dx, dy, dz,
			input logic [2:0] layer);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		dir_x <= dx;
		dir_y <= dy;
		dir_z <= dz;
		cur_layer <= layer;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(2 * UNIT)) - UNIT);
			2: return $urandom_range(1) ? 32'(UNIT) : -32'(UNIT);
			default: return 0;
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		logic [31:0] r;
		r = 32'(rad[$urandom_range(3)]);
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'(int'($urandom_range(8 * ONE)) - 4 * ONE);
			2: return $urandom_range(1) ? r + $urandom_range(20) : -(r - $urandom_range(20));
			3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 0;
		endcase
	endfunction

	task automatic random_queries(input int count);
		logic [31:0] d[3];
		for (int i = 0; i < count; i++) begin
			d[0] = rand_dir();
			d[1] = rand_dir();
			d[2] = rand_dir();
			// now and then an axis-aligned unit ray
			if ($urandom_range(2) == 0) begin
				d = '{0, 0, 0};
				d[$urandom_range(2)] = $urandom_range(1) ? 32'(UNIT) : -32'(UNIT);
			end
			send_query(rand_pos(), $urandom_range(1) ? rand_pos() : 0, rand_pos(),
				d[0], d[1], d[2], 3'($urandom_range(7)));
		end
		start <= 0;
	endtask

	task automatic configure(input int n, input int e, input int r0, r1, r2, r3);
		drain();
		rad = '{31'(r0), 31'(r1), 31'(r2), 31'(r3)};
		write_reg(REG_LAYER_COUNT, 31'(3'(n)));
		write_reg(REG_RADIUS_0, 31'(r0));
		write_reg(REG_RADIUS_1, 31'(r1));
		write_reg(REG_RADIUS_2, 31'(r2));
		write_reg(REG_RADIUS_3, 31'(r3));
		write_reg(REG_EPSILON, 31'(16'(e)));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset config, every layer code, extremes, surface points
		for (int l = 0; l < 8; l++)
			send_query(ONE / 2, 0, 0, UNIT, 0, 0, 3'(l));
		send_query(ONE, 0, 0, -UNIT, 0, 0, 3'b111);
		send_query(5 * ONE, 0, 0, -UNIT, 0, 0, 3'b111);
		send_query(5 * ONE, 0, 0, UNIT, 0, 0, 3'b111);
		send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			-UNIT, -UNIT, -UNIT, 3'b111);
		send_query(32'h80000000, 32'h80000000, 32'h80000000, UNIT, UNIT, UNIT, 0);
		send_query(0, 0, 0, 0, 0, 0, 0);
		send_query(32'hffffffff, 1, 0, 32'hffffffff, 32'h7fffffff, 32'h80000000, 0);
		start <= 0;
		configure(4, 100, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
		send_query(ONE + ONE / 2, 0, 0, UNIT, 0, 0, 1);
		send_query(ONE + ONE / 2, 0, 0, -UNIT, 0, 0, 1);
		send_query(2 * ONE, 0, 0, UNIT, 0, 0, 1);
		send_query(0, 2 * ONE + 50, 0, 0, -UNIT, 0, 2);
		send_query(ONE / 2, 0, 0, UNIT, 0, 0, 3);
		start <= 0;
		configure(0, 'hffff, 0, 'h7fffffff, 3 * ONE, 4 * ONE);
		send_query(ONE, 0, 0, UNIT, 0, 0, 0);
		send_query(ONE, 0, 0, UNIT, 0, 0, 1);
		start <= 0;

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 72;
				2: idle_pct = 15;
				default: idle_pct = 0;
			endcase
			case (ph)
				0: configure(4, 7, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
				1: configure(3, 0, 0, ONE / 3, 5 * ONE, 'h7fffffff);
				2: configure(7, 'hffff, 10 * ONE, 200 * ONE, 30000 * ONE, 'h7fffffff);
				3: configure(2, 300, $urandom, $urandom, $urandom, $urandom);
				4: configure(5, 1, 3 * ONE, 2 * ONE, ONE, 0);
				5: configure(1, $urandom, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
				6: configure(4, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: configure(4, 20, 2 * ONE, 4 * ONE, 8 * ONE, 16 * ONE);
			endcase
			random_queries(50);
		end

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
